/* rtl/core/pipelined_prime_sieve_defines.svh */
// Assertion macros for the prime sieve chain.
`ifndef PIPELINED_PRIME_SIEVE_DEFINES_SVH
`define PIPELINED_PRIME_SIEVE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/pps_pkg.sv */
// Shared constants, types and link record for the prime sieve chain.
package pps_pkg;

   localparam int PPS_MAX_PRIMES  = 64;
   localparam int PPS_VALUE_BITS  = 16;

   localparam int LINK_VALUE_BITS = 32;
   localparam int LINK_STAGE_BITS = 10;

   localparam int REQ_VALUE_BITS   = 16;
   localparam int RSP_VERDICT_BITS = 3;
   localparam int RSP_STAGE_BITS   = 6;
   localparam int RSP_DIVISOR_BITS = 16;
   localparam int RSP_COUNT_BITS   = 7;

   typedef enum logic [RSP_VERDICT_BITS-1:0] {
      VERDICT_STORED   = 3'd0,
      VERDICT_MULTIPLE = 3'd1,
      VERDICT_FULL     = 3'd2,
      VERDICT_END      = 3'd3,
      VERDICT_INVALID  = 3'd4
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                       vld;
      logic                       first;
      logic                       last;
      logic                       din;
      logic [LINK_VALUE_BITS-1:0] value;
      logic                       found;
      logic                       stored;
      logic [LINK_STAGE_BITS-1:0] stage;
      logic [LINK_VALUE_BITS-1:0] divisor;
   } link_type;

endpackage

/* rtl/core/pipelined_prime_sieve.sv */
// Prime sieve top level: request intake, bit-serial feed and result register.
//
// Request channel (req_valid/req_stall): one candidate value or an end marker.
// A value of two or more is sent MSB first, one bit a cycle, down a chain of
// MAX_PRIMES cells. Each filled cell keeps a running remainder against its
// prime; the first cell that ends at remainder zero marks the request a
// multiple, and a request that no cell divides is stored in the first empty
// cell. Results leave on rsp_valid/rsp_stall, one per request.
// A candidate's latency is set by the bit-serial feed and the walk down the
// chain; end markers and values below two go straight to the result register.
// One request is in flight at a time; the next is taken once the previous
// result sits in the output register, even while that result is stalled.
// An end marker reports the prime count and empties the chain.
// Reset empties the chain and the output register; stored primes are not
// cleared, only forgotten through the fill count.
// A stalled result holds the output register; a finished request then waits.
`include "pipelined_prime_sieve_defines.svh"

module pipelined_prime_sieve #(
   parameter int MAX_PRIMES = pps_pkg::PPS_MAX_PRIMES,
   parameter int VALUE_BITS = pps_pkg::PPS_VALUE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pps_pkg::REQ_VALUE_BITS-1:0]    req_value,
   input  logic                                  req_end_marker,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pps_pkg::RSP_VERDICT_BITS-1:0]  rsp_verdict,
   output logic [pps_pkg::RSP_STAGE_BITS-1:0]    rsp_stage,
   output logic [pps_pkg::RSP_DIVISOR_BITS-1:0]  rsp_divisor,
   output logic [pps_pkg::RSP_COUNT_BITS-1:0]    rsp_prime_count
);
   import pps_pkg::*;

   localparam int CNT_BITS  = $clog2(MAX_PRIMES + 1);
   localparam int BEAT_BITS = $clog2(VALUE_BITS);

   state_type                   state_ff, state_in;
   logic [BEAT_BITS-1:0]        beat_ff, beat_in;
   logic [VALUE_BITS-1:0]       value_ff, value_in;
   logic [VALUE_BITS-1:0]       shift_ff, shift_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   verdict_type                 res_verdict_ff, res_verdict_in;
   logic [RSP_STAGE_BITS-1:0]   res_stage_ff, res_stage_in;
   logic [RSP_DIVISOR_BITS-1:0] res_divisor_ff, res_divisor_in;
   logic [RSP_COUNT_BITS-1:0]   res_count_ff, res_count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   verdict_type                 rsp_verdict_ff, rsp_verdict_in;
   logic [RSP_STAGE_BITS-1:0]   rsp_stage_ff, rsp_stage_in;
   logic [RSP_DIVISOR_BITS-1:0] rsp_divisor_ff, rsp_divisor_in;
   logic [RSP_COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic [VALUE_BITS-1:0]       value_ext;
   link_type                    links [MAX_PRIMES+1];
   link_type                    tail;

   assign value_ext = VALUE_BITS'(req_value);
   assign tail      = links[MAX_PRIMES];

   always_comb begin
      links[0].vld     = state_ff == ST_FEED;
      links[0].first   = beat_ff == '0;
      links[0].last    = beat_ff == BEAT_BITS'(VALUE_BITS - 1);
      links[0].din     = shift_ff[VALUE_BITS-1];
      links[0].value   = LINK_VALUE_BITS'(value_ff);
      links[0].found   = 1'b0;
      links[0].stored  = 1'b0;
      links[0].stage   = '0;
      links[0].divisor = '0;
   end

   for (genvar i = 0; i < MAX_PRIMES; i++) begin : g_cell
      pps_cell #(
         .MAX_PRIMES (MAX_PRIMES),
         .VALUE_BITS (VALUE_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count     (count_ff),
         .link_up   (links[i]),
         .link_down (links[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      beat_ff        <= beat_in;
      value_ff       <= value_in;
      shift_ff       <= shift_in;
      res_verdict_ff <= res_verdict_in;
      res_stage_ff   <= res_stage_in;
      res_divisor_ff <= res_divisor_in;
      res_count_ff   <= res_count_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_stage_ff   <= rsp_stage_in;
      rsp_divisor_ff <= rsp_divisor_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_comb begin
      state_in       = state_ff;
      beat_in        = beat_ff;
      value_in       = value_ff;
      shift_in       = shift_ff;
      count_in       = count_ff;
      res_verdict_in = res_verdict_ff;
      res_stage_in   = res_stage_ff;
      res_divisor_in = res_divisor_ff;
      res_count_in   = res_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_stage_in   = rsp_stage_ff;
      rsp_divisor_in = rsp_divisor_ff;
      rsp_count_in   = rsp_count_ff;
      req_stall      = state_ff != ST_IDLE;

      // drop a taken result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_stage_in   = '0;
               res_divisor_in = '0;
               res_count_in   = RSP_COUNT_BITS'(count_ff);
               if (req_end_marker) begin
                  res_verdict_in = VERDICT_END;
                  count_in       = '0;
                  state_in       = ST_DONE;
               end else if (value_ext < VALUE_BITS'(2)) begin
                  res_verdict_in = VERDICT_INVALID;
                  state_in       = ST_DONE;
               end else begin
                  value_in = value_ext;
                  shift_in = value_ext;
                  beat_in  = '0;
                  state_in = ST_FEED;
               end
            end
         end
         ST_FEED: begin
            shift_in = shift_ff << 1;
            beat_in  = beat_ff + 1'b1;
            if (beat_ff == BEAT_BITS'(VALUE_BITS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (tail.vld && tail.last) begin
               res_stage_in   = '0;
               res_divisor_in = '0;
               res_count_in   = RSP_COUNT_BITS'(count_ff);
               if (tail.found) begin
                  res_verdict_in = VERDICT_MULTIPLE;
                  res_stage_in   = RSP_STAGE_BITS'(tail.stage);
                  res_divisor_in = RSP_DIVISOR_BITS'(tail.divisor);
               end else if (tail.stored) begin
                  res_verdict_in = VERDICT_STORED;
                  res_stage_in   = RSP_STAGE_BITS'(tail.stage);
                  count_in       = CNT_BITS'(count_ff + 1'b1);
                  res_count_in   = RSP_COUNT_BITS'(count_in);
               end else begin
                  res_verdict_in = VERDICT_FULL;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // advance into the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = res_verdict_ff;
               rsp_stage_in   = res_stage_ff;
               rsp_divisor_in = res_divisor_ff;
               rsp_count_in   = res_count_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_stage       = rsp_stage_ff;
   assign rsp_divisor     = rsp_divisor_ff;
   assign rsp_prime_count = rsp_count_ff;

   `PPS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_BITS'(MAX_PRIMES), "fill count exceeds chain length")
   `PPS_ASSERT_SAME(a_tail_in_flight, clock, reset, tail.vld,
      state_ff == ST_FEED || state_ff == ST_DRAIN, "chain output outside a request")
   `PPS_ASSERT_NEXT(a_feed_start, clock, reset,
      req_valid && !req_stall && !req_end_marker && value_ext >= VALUE_BITS'(2),
      state_ff == ST_FEED, "candidate did not start feeding")
   `PPS_ASSERT_NEXT(a_store_counts, clock, reset,
      state_ff == ST_DRAIN && tail.vld && tail.last && !tail.found && tail.stored,
      count_ff == CNT_BITS'($past(count_ff) + 1'b1), "store did not advance fill count")

endmodule

/* rtl/core/pps_cell.sv */
// One sieve cell: holds one prime, reduces the passing bit stream modulo it.
module pps_cell #(
   parameter int MAX_PRIMES = pps_pkg::PPS_MAX_PRIMES,
   parameter int VALUE_BITS = pps_pkg::PPS_VALUE_BITS,
   parameter int INDEX      = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(MAX_PRIMES+1)-1:0]   count,
   input  pps_pkg::link_type                 link_up,
   output pps_pkg::link_type                 link_down
);
   import pps_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_PRIMES + 1);

   logic [VALUE_BITS-1:0] prime_ff;
   logic [VALUE_BITS-1:0] prime_in;
   logic [VALUE_BITS-1:0] rem_ff;
   logic [VALUE_BITS-1:0] rem_in;
   link_type              link_ff;
   link_type              link_in;
   logic                  filled;
   logic                  take;
   logic                  hit;
   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   reduced;

   always_comb begin
      filled  = CNT_BITS'(INDEX) < count;
      shifted = {(link_up.first ? {VALUE_BITS{1'b0}} : rem_ff), link_up.din};
      reduced = (shifted >= {1'b0, prime_ff}) ? shifted - {1'b0, prime_ff} : shifted;
      rem_in  = link_up.vld ? reduced[VALUE_BITS-1:0] : rem_ff;
      take    = link_up.vld && link_up.last && !link_up.found && !link_up.stored;
      hit     = take && filled && (reduced == '0);

      link_in  = link_up;
      prime_in = prime_ff;
      if (hit) begin
         link_in.found   = 1'b1;
         link_in.stage   = LINK_STAGE_BITS'(INDEX);
         link_in.divisor = LINK_VALUE_BITS'(prime_ff);
      end else if (take && !filled) begin
         link_in.stored = 1'b1;
         link_in.stage  = LINK_STAGE_BITS'(INDEX);
         prime_in       = link_up.value[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      prime_ff <= prime_in;
      if (reset) begin
         link_ff.vld <= 1'b0;
      end else begin
         link_ff <= link_in;
      end
   end

   assign link_down = link_ff;

endmodule

/* sim/pipelined_prime_sieve_test.sv */
// Self-checking testbench for the pipelined prime sieve: random stalls, verdict prediction.
module pipelined_prime_sieve_test;
   import pps_pkg::*;

   localparam int CHAIN_DEPTH    = PPS_MAX_PRIMES;
   localparam int PHASE_ITEMS    = 130;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 120;
   localparam int WATCHDOG_LIMIT = 6000;

   typedef struct {
      logic [REQ_VALUE_BITS-1:0] value;
      logic                      end_marker;
   } candidate_type;

   typedef struct {
      verdict_type                 verdict;
      logic [RSP_STAGE_BITS-1:0]   stage;
      logic [RSP_DIVISOR_BITS-1:0] divisor;
      logic [RSP_COUNT_BITS-1:0]   prime_count;
   } sieve_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [REQ_VALUE_BITS-1:0] req_value = '0;
   logic req_end_marker = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [RSP_VERDICT_BITS-1:0] rsp_verdict;
   logic [RSP_STAGE_BITS-1:0] rsp_stage;
   logic [RSP_DIVISOR_BITS-1:0] rsp_divisor;
   logic [RSP_COUNT_BITS-1:0] rsp_prime_count;

   candidate_type     candidate_queue[$];
   sieve_verdict_type verdicts_due[$];

   logic [REQ_VALUE_BITS-1:0] sieve_primes[CHAIN_DEPTH];
   int primes_held = 0;
   int verdict_tally[5] = '{default: 0};
   int candidates_queued = 0;
   int candidates_sent = 0;
   int sieve_errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   pipelined_prime_sieve i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_end_marker  (req_end_marker),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_verdict     (rsp_verdict),
      .rsp_stage       (rsp_stage),
      .rsp_divisor     (rsp_divisor),
      .rsp_prime_count (rsp_prime_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void sieve_predict(input logic [REQ_VALUE_BITS-1:0] value,
                                         input logic end_marker);
      sieve_verdict_type v;
      bit hit;
      v.stage       = '0;
      v.divisor     = '0;
      v.prime_count = RSP_COUNT_BITS'(primes_held);
      hit           = 1'b0;
      if (end_marker) begin
         v.verdict   = VERDICT_END;
         primes_held = 0;
      end else if (value < 2) begin
         v.verdict = VERDICT_INVALID;
      end else begin
         for (int i = 0; i < primes_held && !hit; i++) begin
            if (value % sieve_primes[i] == 0) begin
               hit       = 1'b1;
               v.verdict = VERDICT_MULTIPLE;
               v.stage   = RSP_STAGE_BITS'(i);
               v.divisor = sieve_primes[i];
            end
         end
         if (!hit) begin
            if (primes_held < CHAIN_DEPTH) begin
               sieve_primes[primes_held] = value;
               v.verdict     = VERDICT_STORED;
               v.stage       = RSP_STAGE_BITS'(primes_held);
               primes_held++;
               v.prime_count = RSP_COUNT_BITS'(primes_held);
            end else begin
               v.verdict = VERDICT_FULL;
            end
         end
      end
      verdict_tally[int'(v.verdict)]++;
      verdicts_due.push_back(v);
   endfunction

   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
         sieve_errors++;
      end
   endtask

   // Driver: hold a stalled request, otherwise advance to the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            sieve_predict(req_value, req_end_marker);
            void'(candidate_queue.pop_front());
            candidates_sent++;
         end
         if (candidate_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid      <= 1'b1;
            req_value      <= candidate_queue[0].value;
            req_end_marker <= candidate_queue[0].end_marker;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result against the oldest prediction.
   always @(posedge clock) begin
      sieve_verdict_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, got verdict %0d",
                        $time, rsp_verdict);
               sieve_errors++;
            end else begin
               due = verdicts_due.pop_front();
               check_field("verdict", 32'(due.verdict), 32'(rsp_verdict));
               check_field("stage", 32'(due.stage), 32'(rsp_stage));
               check_field("divisor", 32'(due.divisor), 32'(rsp_divisor));
               check_field("prime_count", 32'(due.prime_count), 32'(rsp_prime_count));
            end
         end
         if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d cycles with no transfer", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_candidate(input int value, input logic end_marker);
      candidate_type c;
      c.value      = REQ_VALUE_BITS'(value);
      c.end_marker = end_marker;
      candidate_queue.push_back(c);
      candidates_queued++;
   endtask

   task automatic push_end();
      push_candidate($urandom_range(65535), 1'b1);
   endtask

   task automatic wait_for_drain();
      while (candidate_queue.size() != 0 || req_valid || verdicts_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic push_directed();
      push_candidate(0, 1'b0);
      push_candidate(1, 1'b0);
      push_end();
      push_candidate(2, 1'b0);
      push_candidate(3, 1'b0);
      push_candidate(2, 1'b0);
      push_candidate(4, 1'b0);
      push_candidate(9, 1'b0);
      push_candidate(65535, 1'b0);
      push_candidate(32768, 1'b0);
      push_candidate(25, 1'b0);
      push_candidate(5, 1'b0);
      push_candidate(125, 1'b0);
      push_candidate(1, 1'b0);
      push_end();
      push_candidate(65521, 1'b0);
      push_candidate(65535, 1'b0);
      push_candidate(65521, 1'b0);
      push_end();
   endtask

   task automatic push_segment();
      int pick;
      int len;
      int start;
      int cur;
      pick = $urandom_range(99);
      if (pick < 40) begin
         // ordinary sieve run from two upward
         len = $urandom_range(10, 70);
         for (int k = 0; k < len; k++) push_candidate(k + 2, 1'b0);
         if ($urandom_range(9) != 0) push_end();
      end else if (pick < 55) begin
         start = $urandom_range(2, 60000);
         len   = $urandom_range(5, 30);
         cur   = start;
         for (int k = 0; k < len; k++) begin
            push_candidate(cur, 1'b0);
            cur += $urandom_range(1, 3);
         end
         push_end();
      end else if (pick < 70) begin
         // descending values are never divided by stored ones: fill the chain
         start = $urandom_range(50000, 65535);
         cur   = start;
         len   = CHAIN_DEPTH + $urandom_range(2, 10);
         push_end();
         for (int k = 0; k < len; k++) begin
            push_candidate(cur, 1'b0);
            cur -= $urandom_range(1, 400);
         end
         push_candidate(start, 1'b0);
         push_candidate($urandom_range(1), 1'b0);
         if ($urandom_range(4) != 0) push_end();
      end else if (pick < 85) begin
         len = $urandom_range(5, 20);
         for (int k = 0; k < len; k++) begin
            case ($urandom_range(3))
               0: push_candidate($urandom_range(1), 1'b0);
               1: push_candidate($urandom_range(2, 50), 1'b0);
               default: push_candidate($urandom_range(65535), 1'b0);
            endcase
            if ($urandom_range(9) == 0) push_end();
         end
      end else begin
         start = $urandom_range(2, 1000);
         push_candidate(start, 1'b0);
         push_candidate(start, 1'b0);
         len = $urandom_range(3, 6);
         for (int k = 2; k <= len; k++) push_candidate(start * k, 1'b0);
         if ($urandom_range(1) != 0) push_end();
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct);
      int phase_start;
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      phase_start   = candidates_queued;
      while (candidates_queued - phase_start < PHASE_ITEMS) begin
         push_segment();
         wait_for_drain();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 22;
      recv_idle_pct = 52;
      push_directed();
      wait_for_drain();
      run_phase(22, 52);
      run_phase(52, 22);
      // hold the output long enough for the block to back up its input
      @(negedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_asked++;
      for (int k = 0; k < 30; k++) push_candidate($urandom_range(2, 200), 1'b0);
      push_end();
      wait_for_drain();
      run_phase(0, 0);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run sent %0d requests under three stall mixes plus one long output hold.",
               candidates_sent);
      $display("Verdicts: %0d stored, %0d multiple, %0d full, %0d end, %0d invalid.",
               verdict_tally[VERDICT_STORED], verdict_tally[VERDICT_MULTIPLE],
               verdict_tally[VERDICT_FULL], verdict_tally[VERDICT_END],
               verdict_tally[VERDICT_INVALID]);
      if (verdicts_due.size() != 0)
         $display("%0t: %0d results never arrived", $time, verdicts_due.size());
      if (sieve_errors == 0 && verdicts_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
